FILE: rtl/core/selective_repeat_sender_window_defines.svh
// assertion macros for the checker file
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/srsw_pkg.sv
package srsw_pkg;

  localparam int CNT_W   = 28;
  localparam int MSG_W   = 27;
  localparam int TO_W    = 16;
  localparam int LIM_W   = 8;
  localparam int LEN_W   = 11;
  localparam int SEQ_W   = 16;
  localparam int CFG_W   = 27;
  localparam int CIDX_W  = 3;
  localparam int BURST_W = 5;

  localparam logic [BURST_W-1:0] BURST_MAX = 5'd31;
  localparam logic [4:0] DIV_STEPS = 5'd2;

  localparam logic [CIDX_W-1:0] CFG_MSG_LEN   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_TO   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TO_CAP    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ERR_LIMIT = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MISS_LIM  = 3'd4;

  localparam logic [TO_W-1:0]  RST_INIT_TO = 16'd200;
  localparam logic [TO_W-1:0]  RST_TO_CAP  = 16'd1000;
  localparam logic [LIM_W-1:0] RST_ERR_LIM = 8'd10;
  localparam logic [LIM_W-1:0] RST_MISS    = 8'd5;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ACK   = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_POLL  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ACT_STATUS   = 3'd0,
    ACT_SEND     = 3'd1,
    ACT_RESEND   = 3'd2,
    ACT_FINISHED = 3'd3,
    ACT_LOST     = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DISPATCH,
    ST_ACK_SLIDE,
    ST_ACK_FIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_FLUSH,
    ST_SCAN_HIT,
    ST_SCAN_POST,
    ST_LOST_FLUSH,
    ST_LOST_CAP,
    ST_FINAL
  } ctl_state_t;

  typedef struct packed {
    action_t          action;
    logic [TO_W-1:0]  timeout;
    logic [SEQ_W-1:0] next;
    logic [SEQ_W-1:0] base;
    logic             last;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq;
  } result_t;

  typedef struct packed {
    logic in_load;
    logic div_step;
    logic start_apply;
    logic ack_mark;
    logic slide_step;
    logic ack_finish;
    logic tick_begin;
    logic poll_update;
    logic cap_status;
    logic scan_read;
    logic scan_next;
    logic scan_hit;
    logic scan_post;
    logic cap_lost;
    logic push;
    logic push_end;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    req_t req;
    logic finished;
    logic poll_ok;
    logic slide_more;
    logic scan_done;
    logic hit;
    logic lost;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/selective_repeat_sender_window.sv
// channel  dir  handshake          fields
// s        in   s_tvalid/s_tready  tuser: req_type; tdata: ack_number, ack_flag,
//                                  checksum_ok, ack_last_flag
// m        out  m_tvalid/m_tready  tuser: action; tdata: seq_num, payload_length,
//                                  last_packet, window_base, next_sequence,
//                                  timeout_now; tlast: run_end
// cfg      in   cfg_we             cfg_index, cfg_data
//
// one word in flight: the sequencer takes it and derives the packet count (reciprocal
// multiply, then remainder), then acts on it: ack slides the window one slot per step;
// poll and start give a single word; tick scans the outstanding slots, up to WINDOW, and
// resends each that timed out; a tick when finished gives a status word. a full output
// register holds the sequencer until m_tready. rst is synchronous and clears the window,
// timers and configuration to their defaults.
module selective_repeat_sender_window import srsw_pkg::*; #(
  parameter int WINDOW        = 32,
  parameter int SEGMENT_BYTES = 1024,
  parameter int SEQ_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // ack_number, ack_flag, checksum_ok, ack_last_flag
  input  logic [1:0]        s_tuser,   // req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,   // seq_num, payload_length, last_packet,
                                       // window_base, next_sequence, timeout_now
  output logic [2:0]        m_tuser,   // action
  output logic              m_tlast,   // run_end
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  out_word;

  srsw_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srsw_dp #(
    .WINDOW        (WINDOW),
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .SEQ_BITS      (SEQ_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_word  (out_word),
    .out_end   (m_tlast)
  );

  assign m_tdata = {4'b0, out_word.timeout, out_word.next, out_word.base,
                    out_word.last, out_word.len, out_word.seq};
  assign m_tuser = out_word.action;

endmodule

FILE: rtl/core/srsw_dp.sv
module srsw_dp import srsw_pkg::*; #(
  parameter int WINDOW        = 32,
  parameter int SEGMENT_BYTES = 1024,
  parameter int SEQ_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [23:0]       in_data,
  input  logic [1:0]        in_user,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output result_t           out_word,
  output logic              out_end
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int REM_W  = $clog2(SEGMENT_BYTES) + 1;
  localparam int DIV_K  = MSG_W + $clog2(SEGMENT_BYTES);
  localparam int RCP_W  = MSG_W + 2;
  localparam int PROD_W = MSG_W + RCP_W;
  localparam logic [31:0] SEQ_MASK = 32'((64'd1 << SEQ_BITS) - 64'd1);
  // rounded-up reciprocal, exact floor quotient for every message length
  localparam logic [RCP_W-1:0] DIV_RCP =
    RCP_W'(((64'd1 << DIV_K) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));
  localparam logic [MSG_W-1:0]  SEG_MSG  = MSG_W'(SEGMENT_BYTES);
  localparam logic [LEN_W-1:0]  SEG_LEN  = LEN_W'(SEGMENT_BYTES);
  localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
  localparam logic [SLOT_W:0]   WIN_SUM  = (SLOT_W+1)'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_TOP) ? '0 : s + 1'b1;
  endfunction

  // configuration
  logic [MSG_W-1:0] msg_len;
  logic [TO_W-1:0]  init_to, to_cap;
  logic [LIM_W-1:0] err_lim, miss_lim;

  // latched input word
  req_t        req;
  logic [15:0] ack_num;
  logic        ack_flag, ack_chk, ack_last;

  // packet count
  logic [MSG_W-1:0]  dvd, quo, quo_c, rem_full;
  logic [REM_W-1:0]  rem;
  logic [4:0]        div_cnt;
  logic [PROD_W-1:0] div_prod;

  // window state
  logic [CNT_W-1:0]  base, next, scan_i, ack_idx;
  logic [SLOT_W-1:0] base_slot, next_slot, scan_slot;
  logic [WINDOW-1:0] running, acked;
  logic [31:0]       stamp_mem [WINDOW];
  logic [31:0]       stamp_rd, time_now;
  logic [TO_W-1:0]   cur_to;
  logic [LIM_W-1:0]  resend;
  logic              finished, ack_ok;
  logic [BURST_W-1:0] burst;

  result_t pend;
  logic    pend_valid;

  logic [CNT_W-1:0]  groups, pk_idx, ack_idx_c;
  logic [LEN_W-1:0]  last_len, pk_len;
  logic              pk_last;
  logic [SEQ_W-1:0]  pk_seq, base16, next16;
  logic [31:0]       off, elapsed;
  logic              ack_valid;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] ack_slot;
  logic [TO_W-1:0]   init_eff, cap_eff, grown_to;
  logic [TO_W:0]     grown;
  logic [LIM_W-1:0]  resend_inc;
  logic [CNT_W:0]    next_p1;
  logic              new_fin, mem_we;
  logic [SLOT_W-1:0] mem_waddr;

  assign div_prod = PROD_W'(dvd) * PROD_W'(DIV_RCP);
  assign quo_c    = MSG_W'(div_prod >> DIV_K);
  assign rem_full = dvd - quo * SEG_MSG;

  assign groups   = CNT_W'(quo) + CNT_W'(rem != '0);
  assign last_len = (rem != '0) ? LEN_W'(rem) : SEG_LEN;

  assign base16 = SEQ_W'(32'(base) & SEQ_MASK);
  assign next16 = SEQ_W'(32'(next) & SEQ_MASK);

  // packet fields for a send or a resend
  assign pk_idx  = cmd.poll_update ? next : scan_i;
  assign pk_seq  = SEQ_W'(32'(pk_idx) & SEQ_MASK);
  assign pk_last = (groups != '0) && (pk_idx == groups - 1'b1);
  assign pk_len  = pk_last ? last_len : SEG_LEN;

  // ack window check
  assign off       = (32'(ack_num) - 32'(base)) & SEQ_MASK;
  assign ack_valid = !finished && ack_flag && ack_chk && (off < 32'(WINDOW));
  assign ack_idx_c = base + CNT_W'(off[SLOT_W-1:0]);
  assign slot_sum  = {1'b0, base_slot} + {1'b0, off[SLOT_W-1:0]};
  assign ack_slot  = (slot_sum >= WIN_SUM) ? SLOT_W'(slot_sum - WIN_SUM) : SLOT_W'(slot_sum);
  assign new_fin   = finished || (ack_ok && ((base == groups) ||
                     (ack_last && groups != '0 && ack_idx == groups - 1'b1)));

  assign elapsed    = time_now - stamp_rd;
  assign resend_inc = (resend == '1) ? resend : resend + 1'b1;
  assign next_p1    = {1'b0, next} + 1'b1;
  assign init_eff   = (init_to == '0) ? TO_W'(1) : init_to;
  assign cap_eff    = (to_cap == '0) ? TO_W'(1) : to_cap;
  assign grown      = (TO_W+1)'(cur_to) + (TO_W+1)'(cur_to >> 1);
  assign grown_to   = (grown > (TO_W+1)'(cap_eff)) ? cap_eff : grown[TO_W-1:0];

  assign mem_we    = cmd.poll_update || cmd.scan_hit;
  assign mem_waddr = cmd.poll_update ? next_slot : scan_slot;

  always_comb begin
    stat.div_done   = (div_cnt == '0);
    stat.req        = req;
    stat.finished   = finished;
    stat.poll_ok    = !finished && (next < groups) && ((next - base) < WIN_CNT);
    stat.slide_more = (base < next) && acked[base_slot];
    stat.scan_done  = (scan_i >= next) || (burst >= BURST_MAX);
    stat.hit        = running[scan_slot] && !acked[scan_slot] && (elapsed > 32'(cur_to));
    stat.lost       = (next_p1 >= {1'b0, groups}) && (resend >= err_lim);
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len  <= '0;
      init_to  <= RST_INIT_TO;
      to_cap   <= RST_TO_CAP;
      err_lim  <= RST_ERR_LIM;
      miss_lim <= RST_MISS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MSG_LEN:   msg_len  <= cfg_data[MSG_W-1:0];
        CFG_INIT_TO:   init_to  <= cfg_data[TO_W-1:0];
        CFG_TO_CAP:    to_cap   <= cfg_data[TO_W-1:0];
        CFG_ERR_LIMIT: err_lim  <= cfg_data[LIM_W-1:0];
        CFG_MISS_LIM:  miss_lim <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input latch; quotient by reciprocal multiply, then the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.in_load) begin
      req      <= req_t'(in_user);
      ack_num  <= in_data[15:0];
      ack_flag <= in_data[16];
      ack_chk  <= in_data[17];
      ack_last <= in_data[18];
      dvd      <= msg_len;
      quo      <= '0;
      rem      <= '0;
      div_cnt  <= DIV_STEPS;
    end else if (cmd.div_step) begin
      if (div_cnt == DIV_STEPS) begin
        quo <= quo_c;
      end else begin
        rem <= REM_W'(rem_full);
      end
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= time_now;
    end
    if (cmd.scan_read) begin
      stamp_rd <= stamp_mem[scan_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      next      <= '0;
      base_slot <= '0;
      next_slot <= '0;
      running   <= '0;
      acked     <= '0;
      time_now  <= '0;
      cur_to    <= RST_INIT_TO;
      resend    <= '0;
      finished  <= 1'b0;
      ack_ok    <= 1'b0;
      scan_i    <= '0;
      scan_slot <= '0;
      burst     <= '0;
    end else begin
      if (cmd.start_apply) begin
        base      <= '0;
        next      <= '0;
        base_slot <= '0;
        next_slot <= '0;
        running   <= '0;
        acked     <= '0;
        cur_to    <= init_eff;
        resend    <= '0;
        finished  <= (groups == '0);
      end
      if (cmd.ack_mark) begin
        ack_ok  <= ack_valid;
        ack_idx <= ack_idx_c;
        if (ack_valid) begin
          resend <= '0;
          if (ack_idx_c < next) begin
            acked[ack_slot]   <= 1'b1;
            running[ack_slot] <= 1'b0;
          end
        end
      end
      if (cmd.slide_step) begin
        acked[base_slot] <= 1'b0;
        base             <= base + 1'b1;
        base_slot        <= slot_inc(base_slot);
      end
      if (cmd.ack_finish) begin
        finished <= new_fin;
      end
      if (cmd.tick_begin) begin
        time_now  <= time_now + 1'b1;
        scan_i    <= base;
        scan_slot <= base_slot;
        burst     <= '0;
      end
      if (cmd.poll_update) begin
        running[next_slot] <= 1'b1;
        acked[next_slot]   <= 1'b0;
        next               <= next + 1'b1;
        next_slot          <= slot_inc(next_slot);
      end
      if (cmd.scan_hit) begin
        resend <= resend_inc;
        burst  <= burst + 1'b1;
      end
      if (cmd.scan_next || cmd.scan_post) begin
        scan_i    <= scan_i + 1'b1;
        scan_slot <= slot_inc(scan_slot);
      end
      // timeout grows after too many misses while packets remain
      if (cmd.scan_post && (resend > miss_lim) && (next_p1 < {1'b0, groups})) begin
        cur_to <= grown_to;
        resend <= '0;
      end
      if (cmd.cap_lost) begin
        finished <= 1'b1;
      end
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        out_word   <= pend;
        out_end    <= cmd.push_end;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.start_apply) begin
        pend.action  <= (groups == '0) ? ACT_FINISHED : ACT_STATUS;
        pend.seq     <= '0;
        pend.len     <= '0;
        pend.last    <= 1'b0;
        pend.base    <= '0;
        pend.next    <= '0;
        pend.timeout <= init_eff;
        pend_valid   <= 1'b1;
      end
      if (cmd.ack_finish) begin
        pend.action  <= (!finished && new_fin) ? ACT_FINISHED : ACT_STATUS;
        pend.seq     <= '0;
        pend.len     <= '0;
        pend.last    <= 1'b0;
        pend.base    <= base16;
        pend.next    <= next16;
        pend.timeout <= cur_to;
        pend_valid   <= 1'b1;
      end
      if (cmd.cap_status || cmd.cap_lost) begin
        pend.action  <= cmd.cap_lost ? ACT_LOST : ACT_STATUS;
        pend.seq     <= '0;
        pend.len     <= '0;
        pend.last    <= 1'b0;
        pend.base    <= base16;
        pend.next    <= next16;
        pend.timeout <= cur_to;
        pend_valid   <= 1'b1;
      end
      if (cmd.poll_update || cmd.scan_hit) begin
        pend.action  <= cmd.poll_update ? ACT_SEND : ACT_RESEND;
        pend.seq     <= pk_seq;
        pend.len     <= pk_len;
        pend.last    <= pk_last;
        pend.base    <= base16;
        pend.next    <= cmd.poll_update ? SEQ_W'(32'(next + 1'b1) & SEQ_MASK) : next16;
        pend.timeout <= cur_to;
        pend_valid   <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/srsw_ctl.sv
module srsw_ctl import srsw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DIV;
      ST_DIV:       if (stat.div_done) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (stat.req)
          REQ_START: state_next = ST_FINAL;
          REQ_ACK:   state_next = ST_ACK_SLIDE;
          REQ_TICK:  state_next = stat.finished ? ST_FINAL : ST_SCAN_RD;
          REQ_POLL:  state_next = ST_FINAL;
          default:   state_next = ST_FINAL;
        endcase
      end
      ST_ACK_SLIDE: if (!stat.slide_more) state_next = ST_ACK_FIN;
      ST_ACK_FIN:   state_next = ST_FINAL;
      ST_SCAN_RD:   state_next = stat.scan_done ? ST_FINAL : ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!stat.hit) state_next = ST_SCAN_RD;
        else if (stat.pend_valid) state_next = ST_SCAN_FLUSH;
        else state_next = ST_SCAN_HIT;
      end
      ST_SCAN_FLUSH: if (stat.out_free) state_next = ST_SCAN_HIT;
      ST_SCAN_HIT:   state_next = ST_SCAN_POST;
      ST_SCAN_POST:  state_next = stat.lost ? ST_LOST_FLUSH : ST_SCAN_RD;
      ST_LOST_FLUSH: if (stat.out_free) state_next = ST_LOST_CAP;
      ST_LOST_CAP:   state_next = ST_FINAL;
      ST_FINAL:      if (stat.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_DIV: cmd.div_step = !stat.div_done;
      ST_DISPATCH: begin
        case (stat.req)
          REQ_START: cmd.start_apply = 1'b1;
          REQ_ACK:   cmd.ack_mark = 1'b1;
          REQ_TICK: begin
            cmd.tick_begin = 1'b1;
            cmd.cap_status = stat.finished;
          end
          REQ_POLL: begin
            cmd.poll_update = stat.poll_ok;
            cmd.cap_status  = !stat.poll_ok;
          end
          default: ;
        endcase
      end
      ST_ACK_SLIDE: cmd.slide_step = stat.slide_more;
      ST_ACK_FIN:   cmd.ack_finish = 1'b1;
      ST_SCAN_RD: begin
        cmd.scan_read  = !stat.scan_done;
        // no resend this tick: a lone status word ends the run
        cmd.cap_status = stat.scan_done && !stat.pend_valid;
      end
      ST_SCAN_CHK:   cmd.scan_next = !stat.hit;
      ST_SCAN_FLUSH: cmd.push = stat.out_free;
      ST_SCAN_HIT:   cmd.scan_hit = 1'b1;
      ST_SCAN_POST:  cmd.scan_post = !stat.lost;
      ST_LOST_FLUSH: cmd.push = stat.out_free;
      ST_LOST_CAP:   cmd.cap_lost = 1'b1;
      ST_FINAL: begin
        cmd.push     = stat.out_free;
        cmd.push_end = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/srsw_chk.sv
`include "selective_repeat_sender_window_defines.svh"

module srsw_chk import srsw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  `SRSW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")

  `SRSW_ASSERT_NEXT(a_one_word, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")

  `SRSW_ASSERT_NOW(a_no_packet, m_tvalid && (m_tuser == ACT_STATUS || m_tuser == ACT_FINISHED || m_tuser == ACT_LOST), m_tdata[27:0] == 28'd0, "packet fields set on a word without a packet")

  `SRSW_ASSERT_NOW(a_run_end, m_tvalid && (m_tuser == ACT_SEND || m_tuser == ACT_FINISHED || m_tuser == ACT_LOST), m_tlast, "single-word outcome without run end")

endmodule

bind selective_repeat_sender_window srsw_chk u_srsw_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: tb/sv/selective_repeat_sender_window_tb.sv
module selective_repeat_sender_window_tb import srsw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 32;
  localparam int SEG = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd5;

  typedef struct {
    req_t        req;
    logic [15:0] num;
    bit          flag;
    bit          ck;
    bit          lastf;
    bit          rel;      // ack number taken relative to the current base
    int unsigned off;
  } req_item_t;

  typedef struct {
    action_t     action;
    logic [15:0] seq;
    logic [10:0] len;
    bit          last;
    logic [15:0] base;
    logic [15:0] next;
    logic [15:0] tmo;
    bit          run_end;
  } word_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;  // ack_number, ack_flag, checksum_ok, ack_last_flag
  logic [1:0] s_tuser = '0;   // req_type
  logic m_tvalid;
  logic m_tready = 0;
  logic [79:0] m_tdata;       // seq_num, payload_length, last_packet,
                              // window_base, next_sequence, timeout_now
  logic [2:0] m_tuser;        // action
  logic m_tlast;
  logic cfg_we = 0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  selective_repeat_sender_window dut (.*);

  always #5 clk = ~clk;

  // window model
  int unsigned msg_len, init_to, to_cap, err_lim, miss_lim;
  int unsigned base_cnt, next_cnt, now_ms, cur_to, resends;
  bit running[WIN];
  bit acked[WIN];
  int unsigned stamp[WIN];
  bit done_flag;

  req_item_t pending[$];
  word_t expected_words[$];
  req_item_t cur;
  bit in_busy = 0;
  int in_gap = 0, out_hold = 0, long_hold = 0;
  bit fast = 0;
  int errors = 0, stall = 0;

  function automatic int unsigned pkt_count();
    return (msg_len + SEG - 1) / SEG;
  endfunction

  function automatic void emit_word(action_t a, int unsigned idx, bit pkt);
    word_t w;
    int unsigned g;
    g = pkt_count();
    w.action = a;
    w.seq = '0;
    w.len = '0;
    w.last = 0;
    if (pkt) begin
      w.seq = idx[15:0];
      if (g != 0 && idx == g - 1) begin
        w.last = 1;
        w.len = 11'(msg_len - (g - 1) * SEG);
      end else begin
        w.len = 11'(SEG);
      end
    end
    w.base = base_cnt[15:0];
    w.next = next_cnt[15:0];
    w.tmo = cur_to[15:0];
    w.run_end = 0;
    expected_words = {expected_words, w};
  endfunction

  function automatic int tick_scan();
    int n;
    int unsigned s, g, t, cap;
    n = 0;
    g = pkt_count();
    now_ms++;
    if (done_flag) return 0;
    for (int unsigned i = base_cnt; i < next_cnt; i++) begin
      s = i % WIN;
      if (n >= 31) break;
      if (!running[s] || acked[s]) continue;
      if (now_ms - stamp[s] <= cur_to) continue;
      stamp[s] = now_ms;
      if (resends < 255) resends++;
      emit_word(ACT_RESEND, i, 1);
      n++;
      if (next_cnt + 1 >= g && resends >= err_lim) begin
        done_flag = 1;
        emit_word(ACT_LOST, 0, 0);
        return n + 1;
      end
      if (resends > miss_lim && next_cnt + 1 < g) begin
        t = cur_to + cur_to / 2;
        cap = (to_cap == 0) ? 1 : to_cap;
        cur_to = (t > cap) ? cap : t;
        resends = 0;
      end
    end
    return n;
  endfunction

  function automatic void predict_step(req_item_t it);
    bit was;
    int unsigned off, idx, g;
    g = pkt_count();
    case (it.req)
      REQ_START: begin
        base_cnt = 0;
        next_cnt = 0;
        foreach (running[i]) begin
          running[i] = 0;
          acked[i] = 0;
          stamp[i] = 0;
        end
        cur_to = (init_to == 0) ? 1 : init_to;
        resends = 0;
        done_flag = (g == 0);
        emit_word(done_flag ? ACT_FINISHED : ACT_STATUS, 0, 0);
      end
      REQ_ACK: begin
        was = done_flag;
        off = 32'(16'(it.num - base_cnt[15:0]));
        if (!done_flag && it.flag && it.ck && off < WIN) begin
          resends = 0;
          idx = base_cnt + off;
          if (idx < next_cnt) begin
            acked[idx % WIN] = 1;
            running[idx % WIN] = 0;
          end
          while (base_cnt < next_cnt && acked[base_cnt % WIN]) begin
            acked[base_cnt % WIN] = 0;
            base_cnt++;
          end
          if (base_cnt == g || (it.lastf && g != 0 && idx == g - 1)) done_flag = 1;
        end
        emit_word((!was && done_flag) ? ACT_FINISHED : ACT_STATUS, 0, 0);
      end
      REQ_TICK: begin
        if (tick_scan() == 0) emit_word(ACT_STATUS, 0, 0);
      end
      default: begin
        if (!done_flag && next_cnt < g && next_cnt - base_cnt < WIN) begin
          running[next_cnt % WIN] = 1;
          acked[next_cnt % WIN] = 0;
          stamp[next_cnt % WIN] = now_ms;
          next_cnt++;
          emit_word(ACT_SEND, next_cnt - 1, 1);
        end else begin
          emit_word(ACT_STATUS, 0, 0);
        end
      end
    endcase
    expected_words[$].run_end = 1;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // sender side
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_step(cur);
      in_busy = 0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 0;
      end else if (pending.size() != 0) begin
        cur = pending[0];
        pending.delete(0);
        if (cur.rel) cur.num = base_cnt[15:0] + 16'(cur.off);
        s_tuser <= cur.req;
        s_tdata <= {5'd0, cur.lastf, cur.ck, cur.flag, cur.num};
        s_tvalid <= 1;
        in_busy = 1;
        in_gap = fast ? 0 : $urandom_range(0, 17);
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver side
  always @(posedge clk) begin
    word_t e;
    if (!rst && m_tvalid && m_tready) begin
      out_hold = fast ? 0 : $urandom_range(0, 17);
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word action %0d", m_tuser));
      end else begin
        e = expected_words[0];
        expected_words.delete(0);
        if (m_tuser !== e.action)
          report($sformatf("action %0d, want %0d", m_tuser, e.action));
        if (m_tdata[15:0] !== e.seq)
          report($sformatf("seq %0d, want %0d", m_tdata[15:0], e.seq));
        if (m_tdata[26:16] !== e.len)
          report($sformatf("length %0d, want %0d", m_tdata[26:16], e.len));
        if (m_tdata[27] !== e.last)
          report($sformatf("last %0b, want %0b", m_tdata[27], e.last));
        if (m_tdata[43:28] !== e.base)
          report($sformatf("base %0d, want %0d", m_tdata[43:28], e.base));
        if (m_tdata[59:44] !== e.next)
          report($sformatf("next %0d, want %0d", m_tdata[59:44], e.next));
        if (m_tdata[75:60] !== e.tmo)
          report($sformatf("timeout %0d, want %0d", m_tdata[75:60], e.tmo));
        if (m_tlast !== e.run_end)
          report($sformatf("tlast %0b, want %0b", m_tlast, e.run_end));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (long_hold > 0) begin
      long_hold--;
      m_tready <= 0;
    end else if (out_hold > 0) begin
      out_hold--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && (pending.size() != 0 || in_busy || expected_words.size() != 0)) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end else begin
      stall = 0;
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_MSG_LEN:   msg_len = val & 32'h7FFFFFF;
      CFG_INIT_TO:   init_to = val & 32'hFFFF;
      CFG_TO_CAP:    to_cap = val & 32'hFFFF;
      CFG_ERR_LIMIT: err_lim = val & 32'hFF;
      CFG_MISS_LIM:  miss_lim = val & 32'hFF;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned len, int unsigned ito, int unsigned cap,
                         int unsigned el, int unsigned ml);
    write_reg(CFG_MSG_LEN, len);
    write_reg(CFG_INIT_TO, ito);
    write_reg(CFG_TO_CAP, cap);
    write_reg(CFG_ERR_LIMIT, el);
    write_reg(CFG_MISS_LIM, ml);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_busy || expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void add(req_t r, bit rel = 0, int unsigned off = 0,
                              bit flag = 1, bit ck = 1, bit lastf = 0,
                              logic [15:0] num = '0);
    req_item_t it;
    it.req = r;
    it.rel = rel;
    it.off = off;
    it.flag = flag;
    it.ck = ck;
    it.lastf = lastf;
    it.num = num;
    pending = {pending, it};
  endfunction

  function automatic void add_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) add(REQ_START);
    else if (r < 38) add(REQ_POLL);
    else if (r < 68) begin
      if ($urandom_range(0, 99) < 85)
        add(REQ_ACK, 1, $urandom_range(0, 35), $urandom_range(0, 9) != 0,
            $urandom_range(0, 9) != 0, $urandom_range(0, 5) == 0);
      else
        add(REQ_ACK, 0, 0, $urandom_range(0, 1), $urandom_range(0, 1),
            $urandom_range(0, 1), 16'($urandom));
    end else add(REQ_TICK);
  endfunction

  initial begin
    msg_len = 0; init_to = 200; to_cap = 1000; err_lim = 10; miss_lim = 5;
    base_cnt = 0; next_cnt = 0; now_ms = 0; cur_to = 200; resends = 0; done_flag = 0;
    foreach (running[i]) begin
      running[i] = 0;
      acked[i] = 0;
      stamp[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset defaults: empty message finishes at once
    add(REQ_START);
    add(REQ_POLL);
    add(REQ_TICK);
    add(REQ_ACK, 1, 0);
    wait_idle();

    // six packets, short last one, fast timers
    set_all(5 * SEG + 7, 2, 3, 255, 1);
    write_reg(CFG_UNUSED, 27'h7FFFFFF);
    add(REQ_START);
    repeat (7) add(REQ_POLL);
    add(REQ_ACK, 1, 1, 0, 1);
    add(REQ_ACK, 1, 1, 1, 0);
    add(REQ_ACK, 1, 40);
    repeat (4) add(REQ_TICK);
    add(REQ_ACK, 1, 2);
    add(REQ_ACK, 1, 0);
    add(REQ_ACK, 1, 5, 1, 1, 1);
    add(REQ_TICK);
    add(REQ_POLL);
    add(REQ_ACK, 0, 0, 1, 1, 1, 16'hFFFF);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(40 * SEG, 3, 65535, 255, 3);
        1: set_all(27'h7FFFFFF, 65535, 65535, 255, 255);
        2: set_all(3000, 1, 1, 1, 0);
        3: set_all(1, 0, 0, 255, 0);
        default: set_all(20000, 4, 10, 8, 2);
      endcase
      fast = (ph == 0);
      // all but the last phase restart; the last changes the length mid-transfer and keeps the old window running
      if (ph != 4) add(REQ_START);
      if (ph == 0) begin
        repeat (45) add(REQ_POLL);
        long_hold = 400;
      end
      repeat (ph == 0 ? 20 : 44) begin
        if (ph < 3 || $urandom_range(0, 3) != 0) add_random();
        else add(REQ_TICK);
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
